// ----- sv/rde_pkg.sv -----
// Package for the reversible deque engine: item types, mode codes and defaults.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VALUE_W   = 16;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REVERSE = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] element;
    logic               is_error;
    logic               is_empty;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/rde_store.sv -----
// Single-port synchronous store for the deque ring; reads are registered.
// Depends on rde_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module rde_store #(
  parameter int unsigned DEPTH = rde_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [rde_pkg::VALUE_W-1:0] wr_data,
  output logic      [rde_pkg::VALUE_W-1:0] rd_data
);

  logic [rde_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/rde_ctrl.sv -----
// Deque control: head, count, orientation and error flags, drain sequencer, result register.
// Depends on rde_pkg; drives the rde_store port and takes its read data.
`timescale 1ns / 1ps
`default_nettype none

module rde_ctrl #(
  parameter int unsigned DEPTH = rde_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire rde_pkg::in_item_t           in_item,
  output logic                             busy,
  output logic                             out_valid,
  output rde_pkg::out_item_t               out_item,
  output logic                             mem_wr,
  output logic                             mem_rd,
  output logic      [AW-1:0]               mem_addr,
  output logic      [rde_pkg::VALUE_W-1:0] mem_wdata,
  input  wire logic [rde_pkg::VALUE_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] HEAD_MAX = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          failed_r, failed_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          err_r, err_nxt;
  logic          emp_r, emp_nxt;
  logic          last_r, last_nxt;

  logic          accept;
  logic          drain_last;
  logic [CW-1:0] rev_off;
  logic [AW-1:0] off;
  logic [AW:0]   sum;

  assign accept     = start && (state_r == ST_IDLE);
  assign drain_last = (CW'(CW'(idx_r) + CW'(1)) == count_r);
  assign rev_off    = CW'(count_r - CW'(1) - CW'(idx_r));

  always_comb begin
    if (state_r == ST_DRAIN) begin
      off = rev_r ? rev_off[AW-1:0] : idx_r;
    end else begin
      off = count_r[AW-1:0];
    end
    sum = {1'b0, head_r} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      mem_addr = AW'(sum - DEPTH_S);
    end else begin
      mem_addr = sum[AW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    failed_nxt    = failed_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    err_nxt       = err_r;
    emp_nxt       = emp_r;
    last_nxt      = last_r;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (rde_pkg::mode_t'(in_item.mode))
            rde_pkg::MODE_LOAD: begin
              if (count_r == DEPTH_C) begin
                failed_nxt = 1'b1;
              end else begin
                mem_wr    = 1'b1;
                count_nxt = CW'(count_r + CW'(1));
              end
            end
            rde_pkg::MODE_REVERSE: begin
              rev_nxt = !rev_r;
            end
            rde_pkg::MODE_DELETE: begin
              if (count_r == '0) begin
                failed_nxt = 1'b1;
              end else begin
                if (!rev_r) begin
                  head_nxt = (head_r == HEAD_MAX) ? '0 : AW'(head_r + AW'(1));
                end
                count_nxt = CW'(count_r - CW'(1));
              end
            end
            rde_pkg::MODE_FINISH: begin
              if (failed_r || count_r == '0) begin
                out_valid_nxt = 1'b1;
                err_nxt       = failed_r;
                emp_nxt       = !failed_r;
                last_nxt      = 1'b1;
                head_nxt      = '0;
                count_nxt     = '0;
                rev_nxt       = 1'b0;
                failed_nxt    = 1'b0;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        mem_rd        = 1'b1;
        out_valid_nxt = 1'b1;
        err_nxt       = 1'b0;
        emp_nxt       = 1'b0;
        last_nxt      = drain_last;
        if (drain_last) begin
          head_nxt   = '0;
          count_nxt  = '0;
          rev_nxt    = 1'b0;
          failed_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          idx_nxt = AW'(idx_r + AW'(1));
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      failed_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      emp_r       <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      failed_r    <= failed_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      emp_r       <= emp_nxt;
      last_r      <= last_nxt;
    end
  end

  assign busy      = (state_r == ST_DRAIN);
  assign mem_wdata = in_item.value;
  assign out_valid = out_valid_r;

  always_comb begin
    out_item.element  = (err_r || emp_r) ? '0 : mem_rdata;
    out_item.is_error = err_r;
    out_item.is_empty = emp_r;
    out_item.last     = last_r;
  end

endmodule

`default_nettype wire

// ----- sv/reversible_deque_engine_top.sv -----
// Top level of the reversible deque engine: control sequencer plus ring store.
// Depends on rde_pkg, rde_ctrl and rde_store.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------
//   input    | start & !busy             | in_item  (rde_pkg::in_item_t)
//   result   | out_valid                 | out_item (rde_pkg::out_item_t)
//
// Load, reverse and delete never raise busy.
// Finish with the error flag set or nothing held gives one result the next cycle.
// Otherwise finish raises busy while it drains, one store read per element held;
// each result comes in the cycle after its read, through the store's read register.
// Reset is synchronous, active low, and empties the deque; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module reversible_deque_engine_top #(
  parameter int unsigned DEPTH = rde_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire rde_pkg::in_item_t  in_item,
  output logic                    busy,
  output logic                    out_valid,
  output rde_pkg::out_item_t      out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                        mem_wr;
  logic                        mem_rd;
  logic [AW-1:0]               mem_addr;
  logic [rde_pkg::VALUE_W-1:0] mem_wdata;
  logic [rde_pkg::VALUE_W-1:0] mem_rdata;

  rde_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rde_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .rd_en   (mem_rd),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  a_drain_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("drain cycle without a following result");

  a_finish_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == rde_pkg::MODE_FINISH) |=> (out_valid || busy))
    else $error("finish item produced neither a result nor a drain");

  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.is_error || out_item.is_empty)) |->
      (out_item.last && !busy && out_item.element == '0))
    else $error("error or empty result not a lone final item");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("still busy while final result shown");

endmodule

`default_nettype wire
